@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/lbat_pkg.sv @@
// Package of the linked block allocation table: codes, widths and defaults.
`default_nettype none

package lbat_pkg;

  localparam int unsigned BLOCK_COUNT_DEF = 1024;
  localparam int unsigned BLK_W = 12;
  localparam int unsigned LINK_W = BLK_W + 1;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FOLLOW = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_USED    = 2'd2,
    STAT_NOCHAIN = 2'd3
  } status_e;

endpackage

`default_nettype wire

@@ rtl/linked_block_allocation_table.sv @@
// Linked block allocation table: used-bit and link memories with a sequencer.
//
// Usage: the host raises start with operation_i and block_number_i; the item is
// taken at a clock edge where start is high and busy is low. Each item gives
// exactly one result beat on status_o, successor_o and has_successor_o, marked
// by done_o for one cycle; the receiver cannot stall, so it must take it then.
// Timing: memory data and the item are registered at the accepting edge, and
// the result beat is registered from them in state S_EXEC; the receiver takes
// it from the ports while done_o is high.
// Items do not overlap: busy stays high while an item is in work, and a
// successful append also passes through S_LINK, because the old tail's link is
// written in a separate step on the single write port of the link memory.
// Reset: the used-bit memory is cleared by a pass over all BLOCK_COUNT entries,
// one entry per cycle; busy stays high during that pass. The link memory is not
// cleared: every claim writes its block's link, but a follow of a block that
// was never claimed reads an uncleared link. No chain is open after reset.
`default_nettype none

module linked_block_allocation_table #(
  parameter int unsigned BLOCK_COUNT = lbat_pkg::BLOCK_COUNT_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 operation_i,
  input  wire logic [lbat_pkg::BLK_W-1:0] block_number_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [lbat_pkg::BLK_W-1:0]      successor_o,
  output logic                            has_successor_o
);

  localparam int unsigned AW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned BW = lbat_pkg::BLK_W;
  localparam int unsigned LW = lbat_pkg::LINK_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_LINK  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [BW-1:0] tail_q, tail_d;
  logic open_q, open_d;
  logic [BW-1:0] prev_q, prev_d;

  logic [1:0] op_q;
  logic [BW-1:0] blk_q;

  logic done_q, done_d;
  logic [1:0] status_q, status_d;
  logic [BW-1:0] succ_q, succ_d;
  logic has_q, has_d;

  logic used_mem [BLOCK_COUNT];
  logic [LW-1:0] link_mem [BLOCK_COUNT];
  logic used_rd_q;
  logic [LW-1:0] link_rd_q;

  logic used_we, used_wd;
  logic [AW-1:0] used_wa;
  logic link_we;
  logic [AW-1:0] link_wa;
  logic [LW-1:0] link_wd;

  logic accept;
  logic blk_in_range;
  lbat_pkg::status_e claim_st;

  assign accept = start && !busy;
  assign busy = (state_q != S_IDLE);
  assign blk_in_range = ({1'b0, blk_q} < (BW + 1)'(BLOCK_COUNT));

  always_comb begin
    if (!blk_in_range) begin
      claim_st = lbat_pkg::STAT_RANGE;
    end else if (used_rd_q) begin
      claim_st = lbat_pkg::STAT_USED;
    end else begin
      claim_st = lbat_pkg::STAT_OK;
    end
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    tail_d   = tail_q;
    open_d   = open_q;
    prev_d   = prev_q;
    done_d   = 1'b0;
    status_d = lbat_pkg::STAT_OK;
    succ_d   = '0;
    has_d    = 1'b0;
    used_we  = 1'b0;
    used_wa  = blk_q[AW-1:0];
    used_wd  = 1'b1;
    link_we  = 1'b0;
    link_wa  = blk_q[AW-1:0];
    link_wd  = '0;
    unique case (state_q)
      S_CLEAR: begin
        used_we = 1'b1;
        used_wa = clr_q;
        used_wd = 1'b0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(BLOCK_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        case (lbat_pkg::op_e'(op_q))
          lbat_pkg::OP_START: begin
            status_d = claim_st;
            if (claim_st == lbat_pkg::STAT_OK) begin
              used_we = 1'b1;
              link_we = 1'b1;
              tail_d  = blk_q;
              open_d  = 1'b1;
            end else begin
              open_d = 1'b0;
            end
          end
          lbat_pkg::OP_APPEND: begin
            if (!open_q) begin
              status_d = lbat_pkg::STAT_NOCHAIN;
            end else begin
              status_d = claim_st;
              if (claim_st == lbat_pkg::STAT_OK) begin
                used_we = 1'b1;
                link_we = 1'b1;
                prev_d  = tail_q;
                tail_d  = blk_q;
                state_d = S_LINK;
              end
            end
          end
          lbat_pkg::OP_FOLLOW: begin
            if (!blk_in_range) begin
              status_d = lbat_pkg::STAT_RANGE;
            end else begin
              has_d  = link_rd_q[LW-1];
              succ_d = link_rd_q[LW-1] ? link_rd_q[BW-1:0] : '0;
            end
          end
          default: begin
            status_d = lbat_pkg::STAT_OK;
          end
        endcase
      end
      S_LINK: begin
        // The old tail now points at the block claimed in the previous cycle.
        link_we = 1'b1;
        link_wa = prev_q[AW-1:0];
        link_wd = {1'b1, blk_q};
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      tail_q  <= '0;
      open_q  <= 1'b0;
      prev_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      tail_q  <= tail_d;
      open_q  <= open_d;
      prev_q  <= prev_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      blk_q <= block_number_i;
    end
    status_q <= status_d;
    succ_q   <= succ_d;
    has_q    <= has_d;
  end

  // The read address follows the input port, so the data for an accepted
  // item is ready in the cycle after its accepting edge.
  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_rd_q <= used_mem[block_number_i[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_mem[block_number_i[AW-1:0]];
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign successor_o     = succ_q;
  assign has_successor_o = has_q;

endmodule

`default_nettype wire

@@ rtl/lbat_checker.sv @@
// Port-level checker of the linked block allocation table and its bind.
`default_nettype none
`include "assert_macros.svh"

module lbat_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [1:0]                 operation_i,
  input wire logic [lbat_pkg::BLK_W-1:0] block_number_i,
  input wire logic                       done_o,
  input wire logic [1:0]                 status_o,
  input wire logic [lbat_pkg::BLK_W-1:0] successor_o,
  input wire logic                       has_successor_o
);

  logic acc;
  logic succ_seen;
  logic st_ok;
  assign acc = start && !busy;
  assign succ_seen = done_o && has_successor_o;
  assign st_ok = (status_o == lbat_pkg::STAT_OK);

  `ASSERT_STD(a_busy_after_accept, acc |=> busy, "busy did not rise after an accepted beat")
  `ASSERT_STD(a_no_early_result, acc |=> !done_o, "result beat in the cycle after accept")
  `ASSERT_STD(a_result_from_work, done_o |-> $past(busy), "result beat without an item in work")
  `ASSERT_STD(a_single_result, done_o |=> !done_o, "two result beats in a row")
  `ASSERT_STD(a_successor_ok, succ_seen |-> st_ok, "successor with a failing status")

endmodule

bind linked_block_allocation_table lbat_checker u_lbat_checker (.*);

`default_nettype wire
